// ===== hw/rtl/binary_mask_outer_border_scan_defines.svh =====
// assertion macros for the outer-border scan block
`ifndef BINARY_MASK_OUTER_BORDER_SCAN_DEFINES_SVH
`define BINARY_MASK_OUTER_BORDER_SCAN_DEFINES_SVH

`ifndef SYNTHESIS
`define BMOBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmobs check failed");
`define BMOBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmobs check failed");
`else
`define BMOBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BMOBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/bmobs_pkg.sv =====
// shared types and constants of the outer-border scan block
package bmobs_pkg;

    localparam int GRID_SIZE_DEF = 8;
    localparam int ROW_BITS_W    = 8;
    localparam int KIND_W        = 2;
    localparam int COORD_W       = 5;
    localparam int CMDQ_DEPTH    = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET    = 2'd0,
        KIND_BORDER = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    // one scan command handed from front to back
    typedef struct packed {
        t_kind                      kind;
        logic signed [COORD_W-1:0]  y;
        logic                       last;
    } t_cmd_info;

endpackage

// ===== hw/rtl/binary_mask_outer_border_scan.sv =====
// top level of the outer-border scan block
//
//  port group           dir   handshake      payload
//  input rows           in    push / full    i_row_bits
//  coordinate words     out   pop / empty    o_kind, o_coord_x, o_coord_y, o_last
//
// the front takes a row while not full, then, while the queue has room, hands one
// command per cycle to a four-deep queue for each nonempty scan (set cells, up to
// three border rows, end); the back loads a command once its scan is used up and
// emits one coordinate word per cycle while its output is empty or being popped
// full stays high while the front still holds commands of the last row
// reset is synchronous, active low, and returns the row counter to the top row
`include "binary_mask_outer_border_scan_defines.svh"

module binary_mask_outer_border_scan #(
    parameter int GRID_SIZE = bmobs_pkg::GRID_SIZE_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [bmobs_pkg::ROW_BITS_W-1:0]     i_row_bits,
    input  logic                                 pop,
    output logic                                 empty,
    output logic [bmobs_pkg::KIND_W-1:0]         o_kind,
    output logic signed [bmobs_pkg::COORD_W-1:0] o_coord_x,
    output logic signed [bmobs_pkg::COORD_W-1:0] o_coord_y,
    output logic                                 o_last
);

    import bmobs_pkg::*;

    localparam int PAD_W = GRID_SIZE + 2;
    localparam int QW    = PAD_W + $bits(t_cmd_info);

    logic              w_cmd_push;
    logic [PAD_W-1:0]  w_cmd_bits;
    t_cmd_info         w_cmd_info;
    logic              w_q_full;
    logic              w_q_empty;
    logic              w_q_pop;
    logic [QW-1:0]     w_q_rdata;

    bmobs_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_row_bits (i_row_bits),
        .o_full     (full),
        .o_cmd_push (w_cmd_push),
        .o_cmd_bits (w_cmd_bits),
        .o_cmd_info (w_cmd_info),
        .i_cmd_full (w_q_full)
    );

    bmobs_fifo #(
        .WIDTH (QW),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_wdata ({w_cmd_bits, w_cmd_info}),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_rdata (w_q_rdata),
        .o_empty (w_q_empty)
    );

    bmobs_back #(
        .GRID_SIZE (GRID_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_q_empty),
        .o_cmd_pop   (w_q_pop),
        .i_cmd_bits  (w_q_rdata[QW-1 -: PAD_W]),
        .i_cmd_info  (t_cmd_info'(w_q_rdata[$bits(t_cmd_info)-1:0])),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_kind      (o_kind),
        .o_coord_x   (o_coord_x),
        .o_coord_y   (o_coord_y),
        .o_last      (o_last)
    );

    // an end marker always closes its row
    `BMOBS_ASSERT_IMPL(a_end_last, i_clk, i_rst_n, !empty && o_kind == KIND_END, o_last)
    // an end marker carries zero coordinates
    `BMOBS_ASSERT_IMPL(a_end_zero, i_clk, i_rst_n, !empty && o_kind == KIND_END,
        o_coord_x == '0 && o_coord_y == '0)
    // a row with cell 0 set always has work left in the front next cycle
    `BMOBS_ASSERT_NEXT(a_row_busy, i_clk, i_rst_n, push && !full && i_row_bits[0], full)

endmodule

// ===== hw/rtl/bmobs_fifo.sv =====
// small register queue between the front and back parts
module bmobs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bmobs_pkg::CMDQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wp;
    logic [AW:0]      r_rp;
    logic             w_push;
    logic             w_pop;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;
    assign o_rdata = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp[AW-1:0]] <= i_wdata;
        end
    end

endmodule

// ===== hw/rtl/bmobs_front.sv =====
// front part: takes mask rows, builds the scan vectors and queues scan commands
module bmobs_front #(
    parameter int GRID_SIZE = bmobs_pkg::GRID_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic [bmobs_pkg::ROW_BITS_W-1:0]  i_row_bits,
    output logic                              o_full,
    output logic                              o_cmd_push,
    output logic [GRID_SIZE+1:0]              o_cmd_bits,
    output bmobs_pkg::t_cmd_info              o_cmd_info,
    input  logic                              i_cmd_full
);

    import bmobs_pkg::*;

    localparam int PAD_W = GRID_SIZE + 2;
    localparam int RW    = $clog2(GRID_SIZE);
    localparam int NSLOT = 5;
    localparam int SW    = $clog2(NSLOT);

    localparam logic [SW-1:0] SLOT_SET  = 3'd0;
    localparam logic [SW-1:0] SLOT_PREV = 3'd1;
    localparam logic [SW-1:0] SLOT_CUR  = 3'd2;
    localparam logic [SW-1:0] SLOT_NEXT = 3'd3;
    localparam logic [SW-1:0] SLOT_END  = 3'd4;

    // clear cells with a set 4-neighbour, on the padded row
    function automatic logic [PAD_W-1:0] f_border(
        input logic [GRID_SIZE-1:0] above,
        input logic [GRID_SIZE-1:0] at,
        input logic [GRID_SIZE-1:0] below
    );
        logic [PAD_W-1:0] pa;
        logic [PAD_W-1:0] pt;
        logic [PAD_W-1:0] pb;
        pa = {1'b0, above, 1'b0};
        pt = {1'b0, at, 1'b0};
        pb = {1'b0, below, 1'b0};
        return (pa | pb | (pt << 1) | (pt >> 1)) & ~pt;
    endfunction

    logic [GRID_SIZE-1:0]      w_row;
    logic [GRID_SIZE-1:0]      r_older;
    logic [GRID_SIZE-1:0]      r_newer;
    logic [RW-1:0]             r_rows;
    logic [NSLOT-1:0]          r_pend;
    logic [PAD_W-1:0]          r_vec [NSLOT];
    logic signed [COORD_W-1:0] r_y;
    logic                      w_accept;
    logic                      w_final;
    logic [PAD_W-1:0]          w_set;
    logic [PAD_W-1:0]          w_b1;
    logic [PAD_W-1:0]          w_b2;
    logic [PAD_W-1:0]          w_b3;
    logic [SW-1:0]             w_sel;
    logic [NSLOT-1:0]          w_rest;

    for (genvar i = 0; i < GRID_SIZE; i++) begin : g_row
        if (i < ROW_BITS_W) begin : g_in
            assign w_row[i] = i_row_bits[i];
        end else begin : g_zero
            assign w_row[i] = 1'b0;
        end
    end

    assign w_accept = i_push & ~o_full;
    assign w_final  = (r_rows == RW'(GRID_SIZE - 1));
    assign w_set    = {1'b0, w_row, 1'b0};
    assign w_b1     = f_border(r_older, r_newer, w_row);
    assign w_b2     = f_border(r_newer, w_row, '0);
    assign w_b3     = f_border(w_row, '0, '0);

    assign o_full = |r_pend;

    // lowest pending scan goes first
    always_comb begin
        w_sel = '0;
        for (int k = NSLOT - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                w_sel = SW'(k);
            end
        end
    end

    assign w_rest     = r_pend & ~(NSLOT'(1) << w_sel);
    assign o_cmd_push = (|r_pend) & ~i_cmd_full;
    assign o_cmd_bits = r_vec[w_sel];

    always_comb begin
        o_cmd_info.last = ~(|w_rest);
        case (w_sel)
            SLOT_SET: begin
                o_cmd_info.kind = KIND_SET;
                o_cmd_info.y    = r_y;
            end
            SLOT_PREV: begin
                o_cmd_info.kind = KIND_BORDER;
                o_cmd_info.y    = r_y - COORD_W'(1);
            end
            SLOT_CUR: begin
                o_cmd_info.kind = KIND_BORDER;
                o_cmd_info.y    = r_y;
            end
            SLOT_NEXT: begin
                o_cmd_info.kind = KIND_BORDER;
                o_cmd_info.y    = r_y + COORD_W'(1);
            end
            SLOT_END: begin
                o_cmd_info.kind = KIND_END;
                o_cmd_info.y    = '0;
            end
            default: begin
                o_cmd_info.kind = KIND_END;
                o_cmd_info.y    = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_older <= '0;
            r_newer <= '0;
            r_rows  <= '0;
        end else if (w_accept) begin
            r_pend <= {w_final, w_final & (|w_b3), w_final & (|w_b2), |w_b1, |w_set};
            if (w_final) begin
                r_older <= '0;
                r_newer <= '0;
                r_rows  <= '0;
            end else begin
                r_older <= r_newer;
                r_newer <= w_row;
                r_rows  <= r_rows + 1'b1;
            end
        end else if (o_cmd_push) begin
            r_pend <= w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vec[SLOT_SET]  <= w_set;
            r_vec[SLOT_PREV] <= w_b1;
            r_vec[SLOT_CUR]  <= w_b2;
            r_vec[SLOT_NEXT] <= w_b3;
            // end marker is a single-bit scan
            r_vec[SLOT_END]  <= PAD_W'(1);
            r_y              <= COORD_W'(r_rows);
        end
    end

endmodule

// ===== hw/rtl/bmobs_back.sv =====
// back part: walks each scan vector, emitting one coordinate word per cycle unless output is held
module bmobs_back #(
    parameter int GRID_SIZE = bmobs_pkg::GRID_SIZE_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_empty,
    output logic                                 o_cmd_pop,
    input  logic [GRID_SIZE+1:0]                 i_cmd_bits,
    input  bmobs_pkg::t_cmd_info                 i_cmd_info,
    input  logic                                 i_pop,
    output logic                                 o_empty,
    output logic [bmobs_pkg::KIND_W-1:0]         o_kind,
    output logic signed [bmobs_pkg::COORD_W-1:0] o_coord_x,
    output logic signed [bmobs_pkg::COORD_W-1:0] o_coord_y,
    output logic                                 o_last
);

    import bmobs_pkg::*;

    localparam int PAD_W = GRID_SIZE + 2;
    localparam int IW    = $clog2(PAD_W);

    logic [PAD_W-1:0]          r_bits;
    t_cmd_info                 r_info;
    logic                      r_ov;
    logic [KIND_W-1:0]         r_kind;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic                      r_last;
    logic                      w_adv;
    logic                      w_emit;
    logic [IW-1:0]             w_idx;
    logic [PAD_W-1:0]          w_rem;

    always_comb begin
        w_idx = '0;
        for (int k = PAD_W - 1; k >= 0; k--) begin
            if (r_bits[k]) begin
                w_idx = IW'(k);
            end
        end
    end

    assign w_rem     = r_bits & (r_bits - PAD_W'(1));
    assign w_adv     = ~r_ov | i_pop;
    assign w_emit    = (|r_bits) & w_adv;
    assign o_cmd_pop = ~(|r_bits) & ~i_cmd_empty;

    assign o_empty   = ~r_ov;
    assign o_kind    = r_kind;
    assign o_coord_x = r_x;
    assign o_coord_y = r_y;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_bits <= i_cmd_bits;
            end else if (w_emit) begin
                r_bits <= w_rem;
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_info <= i_cmd_info;
        end
        if (w_emit) begin
            r_kind <= r_info.kind;
            // bit i of the padded row is column i-1
            r_x    <= (r_info.kind == KIND_END) ? '0 : (COORD_W'(w_idx) - COORD_W'(1));
            r_y    <= r_info.y;
            r_last <= r_info.last & ~(|w_rem);
        end
    end

endmodule
